// ----- src/sliding_window_average_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH

// property checked on every clock edge outside reset
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define SWA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- src/swa_pkg.sv -----
package swa_pkg;

  // sample and result width
  localparam int unsigned DATA_W = 32;

  // default window length
  localparam int unsigned DEFAULT_WINDOW_LENGTH = 32;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // front state machine
  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_e;

  // back state machine
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_e;

endpackage

// ----- src/swa_fifo.sv -----
`include "sliding_window_average_macros.svh"

module swa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = swa_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] data_o
);
  import swa_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SWA_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "queue occupancy above depth")
  `SWA_ASSERT(a_count_up, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1, "queue count did not grow")
  `SWA_ASSERT(a_ptr_gap, empty |-> wr_ptr_q == rd_ptr_q, "empty queue with pointers apart")

endmodule

// ----- src/swa_front.sv -----
module swa_front #(
  parameter int unsigned WINDOW_LENGTH = swa_pkg::DEFAULT_WINDOW_LENGTH,
  localparam int unsigned PTR_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1,
  localparam int unsigned CNT_W   = $clog2(WINDOW_LENGTH + 1),
  localparam int unsigned SUM_W   = swa_pkg::DATA_W + $clog2(WINDOW_LENGTH),
  localparam int unsigned ENTRY_W = 1 + swa_pkg::DATA_W + CNT_W + SUM_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [swa_pkg::DATA_W-1:0] sample_i,
  input  logic                      use_average_i,
  output logic                      q_push_o,
  input  logic                      q_full_i,
  output logic [ENTRY_W-1:0]        q_data_o
);
  import swa_pkg::*;

  front_state_e state_q, state_d;

  logic [DATA_W-1:0] ring_q [WINDOW_LENGTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0] old_sample;
  logic [PTR_W-1:0]  wpos_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              accept;
  logic              ring_full;

  assign accept = push && !full;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (push) state_d = F_UPDATE;
      end
      F_UPDATE: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full     = 1'b1;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE:   full = 1'b0;
      F_UPDATE: q_push_o = !q_full_i;
      default: begin
        full     = 1'b1;
        q_push_o = 1'b0;
      end
    endcase
  end

  // replaced sample counts as zero until the window has filled once
  assign ring_full  = (fill_q == CNT_W'(WINDOW_LENGTH));
  assign old_sample = ring_full ? rd_q : '0;
  assign sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
  assign fill_d     = ring_full ? fill_q : fill_q + 1'b1;
  assign q_data_o   = {use_average_i, sample_q, fill_d, sum_d};

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wpos_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (q_push_o) begin
        wpos_q <= (wpos_q == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : wpos_q + 1'b1;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

  // sample ring, registered read of the slot to be replaced
  always_ff @(posedge clk_i) begin
    if (q_push_o) begin
      ring_q[wpos_q] <= sample_q;
    end
    rd_q <= ring_q[wpos_q];
  end

endmodule

// ----- src/swa_back.sv -----
`include "sliding_window_average_macros.svh"

module swa_back #(
  parameter int unsigned WINDOW_LENGTH = swa_pkg::DEFAULT_WINDOW_LENGTH,
  localparam int unsigned CNT_W   = $clog2(WINDOW_LENGTH + 1),
  localparam int unsigned SUM_W   = swa_pkg::DATA_W + $clog2(WINDOW_LENGTH),
  localparam int unsigned ENTRY_W = 1 + swa_pkg::DATA_W + CNT_W + SUM_W,
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  input  logic [ENTRY_W-1:0]         q_data_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [swa_pkg::DATA_W-1:0] value_o
);
  import swa_pkg::*;

  back_state_e state_q, state_d;

  logic              e_avg;
  logic [DATA_W-1:0] e_sample;
  logic [CNT_W-1:0]  e_count;
  logic [SUM_W-1:0]  e_sum;

  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] value_q;
  logic              out_valid_q;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic              out_free;
  logic              load_out;

  assign {e_avg, e_sample, e_count, e_sum} = q_data_i;

  // one restoring division step per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign value_o  = value_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) state_d = e_avg ? B_DIV : B_HOLD;
      end
      B_DIV: begin
        if (step_q == STEP_W'(1)) state_d = B_HOLD;
      end
      B_HOLD: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o = !q_empty_i;
      B_DIV:   q_pop_o = 1'b0;
      B_HOLD:  load_out = out_free;
      default: begin
        q_pop_o  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      quo_q  <= e_avg ? e_sum : SUM_W'(e_sample);
      rem_q  <= '0;
      div_q  <= e_count;
      step_q <= STEP_W'(SUM_W);
    end else if (state_q == B_DIV) begin
      quo_q  <= {quo_q[SUM_W-2:0], fits};
      rem_q  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_q <= step_q - 1'b1;
    end
    if (load_out) begin
      value_q <= quo_q[DATA_W-1:0];
    end
  end

  // control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SWA_NEVER(a_div_zero, state_q == B_DIV && div_q == '0, "division by an empty window")
  `SWA_ASSERT(a_quo_fits, load_out |-> (quo_q >> DATA_W) == '0, "result wider than a sample")
  `SWA_ASSERT(a_out_held, out_valid_q && !pop |=> out_valid_q && $stable(value_q), "result dropped")

endmodule

// ----- src/sliding_window_average.sv -----
// sliding window average over the last WINDOW_LENGTH samples
//
// input: a queue-like port. a request carrying sample_i is taken on a clock
// edge with push high and full low. output: a queue-like port. value_o holds
// the oldest result while empty is low; it is taken with pop high.
// config: use_average is written through cfg_valid_i/cfg_data_i, always ready;
// 1 gives the truncated average of the filled slots, 0 the latest sample.
//
// flow: the front takes a request, then reads the slot it replaces from the
// ring and updates the running sum before it takes the next; it waits while
// the queue is full. the back divides the sum by the fill count with a
// 1-bit-per-cycle restoring divider, then hands the result to the output
// register once that is free; in latest mode no division is done. the back
// finishes one result before it pops the next entry. a 2-entry queue decouples them.
// reset empties the window, the queue and the output, and clears use_average;
// no clearing pass is needed. a stalled receiver holds the result steady and
// backs up into the queue and then into full.
module sliding_window_average #(
  parameter int unsigned WINDOW_LENGTH = swa_pkg::DEFAULT_WINDOW_LENGTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [swa_pkg::DATA_W-1:0] sample_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [swa_pkg::DATA_W-1:0] value_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i
);
  import swa_pkg::*;

  localparam int unsigned CNT_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SUM_W   = DATA_W + $clog2(WINDOW_LENGTH);
  localparam int unsigned ENTRY_W = 1 + DATA_W + CNT_W + SUM_W;

  logic               use_average_q;
  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  // mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_average_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      use_average_q <= cfg_data_i;
    end
  end

  // ring, fill count and running sum
  swa_front #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_i     (sample_i),
    .use_average_i(use_average_q),
    .q_push_o     (q_push),
    .q_full_i     (q_full),
    .q_data_o     (q_wdata)
  );

  // decoupling queue
  swa_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (q_push),
    .full  (q_full),
    .data_i(q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .data_o(q_rdata)
  );

  // divider and result register
  swa_back #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .q_data_i (q_rdata),
    .empty    (empty),
    .pop      (pop),
    .value_o  (value_o)
  );

endmodule
